>>> src/ulb_pkg.sv
// ulb_pkg: shared types and constants for the uart line echo buffer
// item structs, opcodes, status codes, memory geometry
// no dependencies
package ulb_pkg;

    localparam int RING_DEPTH = 256;
    localparam int LINE_DEPTH = 64;

    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int RING_FW = $clog2(RING_DEPTH + 1);
    localparam int LINE_AW = $clog2(LINE_DEPTH);
    localparam int LINE_FW = $clog2(LINE_DEPTH + 1);

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [2:0] OP_RX      = 3'd0;
    localparam logic [2:0] OP_TAKE    = 3'd1;
    localparam logic [2:0] OP_WRITE   = 3'd2;
    localparam logic [2:0] OP_RESTART = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_PENDING  = 2'd2;
    localparam logic [1:0] ST_BADINDEX = 2'd3;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] data_byte;
        logic       message_last;
        logic       add_newline;
        logic [5:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       line_ready;
        logic [6:0] line_length;
        logic [7:0] read_byte;
        logic [8:0] tx_level;
        logic [1:0] status;
    } out_item_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] wdata;
    } ring_ctrl_t;

endpackage

>>> src/ulb_ring.sv
// ulb_ring: transmit ring memory with head, tail and fill count
// one write and one registered read per cycle
// depends on ulb_pkg
module ulb_ring (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ulb_pkg::ring_ctrl_t         ctrl,
    output logic [7:0]                  rdata,
    output logic [ulb_pkg::RING_FW-1:0] fill
);

    logic [7:0]                  mem [ulb_pkg::RING_DEPTH];
    logic [ulb_pkg::RING_AW-1:0] head_reg, head_next;
    logic [ulb_pkg::RING_AW-1:0] tail_reg, tail_next;
    logic [ulb_pkg::RING_FW-1:0] fill_reg, fill_next;
    logic [7:0]                  rdata_reg;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (ctrl.push)
        begin
            tail_next = (tail_reg == ulb_pkg::RING_AW'(ulb_pkg::RING_DEPTH - 1)) ?
                        '0 : tail_reg + 1'b1;
        end
        if (ctrl.pop)
        begin
            head_next = (head_reg == ulb_pkg::RING_AW'(ulb_pkg::RING_DEPTH - 1)) ?
                        '0 : head_reg + 1'b1;
        end
        if (ctrl.push && !ctrl.pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (ctrl.pop && !ctrl.push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= ctrl.wdata;
        end
        if (ctrl.pop)
        begin
            rdata_reg <= mem[head_reg];
        end
    end

    assign rdata = rdata_reg;
    assign fill  = fill_reg;

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push && !ctrl.pop |-> fill_reg < ulb_pkg::RING_FW'(ulb_pkg::RING_DEPTH))
        else $error("push into full ring");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> fill_reg != '0)
        else $error("pop from empty ring");

    a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push && !ctrl.pop |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("ring fill did not follow push");

endmodule

>>> src/uart_line_echo_buffer_top.sv
// uart_line_echo_buffer_top: transmit ring plus receive line buffer with echo
// an accepted item passes S_EXEC, then S_PUSH while a line end or a host write still has
// cr lf bytes for the single ring write port, then S_FINISH, which waits for out_ready
// while a previous result is still held in the output register
// an item is taken only when the previous one has finished; the output register
// lets a new item enter while a result waits
// reset: pointers, fill counts and line lock clear at once, memory contents stay undefined
module uart_line_echo_buffer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ulb_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output ulb_pkg::out_item_t out_item
);

    localparam int CMP_W = ulb_pkg::LINE_FW + 6;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_PUSH   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    ulb_pkg::in_item_t           item_reg, item_next;
    logic [1:0]                  pend_reg, pend_next;
    logic [1:0]                  status_reg, status_next;
    logic                        txv_reg, txv_next;
    logic                        rdok_reg, rdok_next;
    logic [ulb_pkg::LINE_FW-1:0] line_fill_reg, line_fill_next;
    logic                        locked_reg, locked_next;
    logic                        out_valid_reg, out_valid_next;
    ulb_pkg::out_item_t          out_reg, out_next;

    logic [7:0]                  line_mem [ulb_pkg::LINE_DEPTH];
    logic [7:0]                  line_q_reg;
    logic                        line_we, line_re;
    logic [ulb_pkg::LINE_AW-1:0] line_addr;

    ulb_pkg::ring_ctrl_t         ring_ctrl;
    logic [7:0]                  ring_rdata;
    logic [ulb_pkg::RING_FW-1:0] ring_fill;
    logic                        room1, room2, room3, crlf, is_eol;

    ulb_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ring_ctrl),
        .rdata (ring_rdata),
        .fill  (ring_fill)
    );

    assign room1 = ring_fill < ulb_pkg::RING_FW'(ulb_pkg::RING_DEPTH);
    assign room2 = ring_fill <= ulb_pkg::RING_FW'(ulb_pkg::RING_DEPTH - 2);
    assign room3 = ring_fill <= ulb_pkg::RING_FW'(ulb_pkg::RING_DEPTH - 3);
    assign crlf  = item_reg.message_last && item_reg.add_newline;
    assign is_eol = (item_reg.data_byte == ulb_pkg::CH_CR) ||
                    (item_reg.data_byte == ulb_pkg::CH_LF);

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        pend_next      = pend_reg;
        status_next    = status_reg;
        txv_next       = txv_reg;
        rdok_next      = rdok_reg;
        line_fill_next = line_fill_reg;
        locked_next    = locked_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        line_we        = 1'b0;
        line_re        = 1'b0;
        line_addr      = ulb_pkg::LINE_AW'(line_fill_reg);
        ring_ctrl      = '{push: 1'b0, pop: 1'b0, wdata: item_reg.data_byte};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next   = in_item;
                    pend_next   = 2'd0;
                    status_next = ulb_pkg::ST_OK;
                    txv_next    = 1'b0;
                    rdok_next   = 1'b0;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (item_reg.opcode)
                    ulb_pkg::OP_RX:
                    begin
                        if (locked_reg)
                        begin
                            status_next = ulb_pkg::ST_PENDING;
                        end
                        else if (is_eol)
                        begin
                            if (line_fill_reg != '0)
                            begin
                                locked_next = 1'b1;
                                if (room2)
                                begin
                                    ring_ctrl.push  = 1'b1;
                                    ring_ctrl.wdata = ulb_pkg::CH_CR;
                                    pend_next       = 2'd1;
                                end
                                else
                                begin
                                    status_next = ulb_pkg::ST_FULL;
                                end
                            end
                        end
                        else
                        begin
                            if (line_fill_reg < ulb_pkg::LINE_FW'(ulb_pkg::LINE_DEPTH))
                            begin
                                line_we        = 1'b1;
                                line_fill_next = line_fill_reg + 1'b1;
                            end
                            if (room1)
                            begin
                                ring_ctrl.push = 1'b1;
                            end
                            else
                            begin
                                status_next = ulb_pkg::ST_FULL;
                            end
                        end
                    end
                    ulb_pkg::OP_TAKE:
                    begin
                        if (ring_fill != '0)
                        begin
                            ring_ctrl.pop = 1'b1;
                            txv_next      = 1'b1;
                        end
                    end
                    ulb_pkg::OP_WRITE:
                    begin
                        if (crlf ? room3 : room1)
                        begin
                            ring_ctrl.push = 1'b1;
                            pend_next      = crlf ? 2'd2 : 2'd0;
                        end
                        else
                        begin
                            status_next = ulb_pkg::ST_FULL;
                        end
                    end
                    ulb_pkg::OP_RESTART:
                    begin
                        line_fill_next = '0;
                        locked_next    = 1'b0;
                    end
                    ulb_pkg::OP_READ:
                    begin
                        line_addr = ulb_pkg::LINE_AW'(item_reg.read_index);
                        if (CMP_W'(item_reg.read_index) < CMP_W'(line_fill_reg))
                        begin
                            line_re   = 1'b1;
                            rdok_next = 1'b1;
                        end
                        else
                        begin
                            status_next = ulb_pkg::ST_BADINDEX;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                state_next = (pend_next != 2'd0) ? S_PUSH : S_FINISH;
            end
            S_PUSH:
            begin
                ring_ctrl.push  = 1'b1;
                ring_ctrl.wdata = (pend_reg == 2'd2) ? ulb_pkg::CH_CR : ulb_pkg::CH_LF;
                pend_next       = pend_reg - 1'b1;
                if (pend_reg == 2'd1)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.tx_valid    = txv_reg;
                    out_next.tx_byte     = txv_reg ? ring_rdata : 8'd0;
                    out_next.line_ready  = locked_reg;
                    out_next.line_length = 7'(line_fill_reg);
                    out_next.read_byte   = rdok_reg ? line_q_reg : 8'd0;
                    out_next.tx_level    = 9'(ring_fill);
                    out_next.status      = status_reg;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 2'd0;
            line_fill_reg <= '0;
            locked_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            line_fill_reg <= line_fill_next;
            locked_reg    <= locked_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        status_reg <= status_next;
        txv_reg    <= txv_next;
        rdok_reg   <= rdok_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_addr] <= item_reg.data_byte;
        end
        if (line_re)
        begin
            line_q_reg <= line_mem[line_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
        line_fill_reg <= ulb_pkg::LINE_FW'(ulb_pkg::LINE_DEPTH))
        else $error("line fill beyond depth");

    a_lock_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        locked_reg |-> line_fill_reg != '0)
        else $error("line locked while empty");

    a_push_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PUSH |-> pend_reg != 2'd0)
        else $error("push state without pending byte");

endmodule
